FILE: hw/rtl/stq_pkg.sv
// Shared types and constants for the sorted timer expiry queue.
`default_nettype none

package stq_pkg;

  // Fixed field widths of the request and result words
  localparam int NUM_IDS = 16;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 32;

  // Request type codes
  localparam logic REQ_ARM  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Request word
  typedef struct packed {
    logic               req_type;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] defer_ticks;
  } stq_in_t;

  // Result word
  typedef struct packed {
    logic            add_status;
    logic            expired_valid;
    logic [ID_W-1:0] expired_id;
    logic            last;
  } stq_out_t;

  // Controller states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EVAL   = 6'b000010,
    ST_REBASE = 6'b000100,
    ST_INCR   = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_DRAIN  = 6'b100000
  } stq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic calc_exp;
    logic rebase;
    logic tick_inc;
    logic insert;
    logic pop;
    logic out_arm;
    logic out_refused;
    logic out_none;
  } stq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_tick;
    logic refused;
    logic wrap;
    logic tick_max;
    logic head_due;
    logic next_due;
  } stq_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_timer_expiry_queue_core.sv
// Top level of the sorted timer expiry queue: controller plus datapath.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------------------
//   request  | start / busy       | in_req  (req_type, timer_id, defer_ticks)
//   result   | out_valid (strobe) | out_res (add_status, expired_valid, id, last)
//
// A request is taken when start is high and busy is low; busy then stays high
// until the last result is registered. An arm passes EVAL and INSERT, with
// REBASE between on a wrap; a refused arm ends in EVAL. A tick passes EVAL,
// REBASE and INCR on a rebase, then DRAIN until none is due. The cell chain
// drains one expiry per cycle from its head; a rebase updates all cells at once.
// Reset (synchronous, rst_n low) empties the queue, clears the armed flags and
// the tick count. Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module sorted_timer_expiry_queue_core import stq_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  stq_in_t  in_req,
  output logic     out_valid,
  output stq_out_t out_res
);

  stq_cmd_t cmd;
  stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  stq_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TICK_BITS  (TICK_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A refused arm is a single final word with no expiry
  a_refused_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.add_status) |-> (out_res.last && !out_res.expired_valid))
    else $error("refused arm result malformed");

  // Expiries drain back to back until the one marked last
  a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |=> (out_valid && out_res.expired_valid))
    else $error("expiry burst broken before last");

  // Insert and pop never share a cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.pop))
    else $error("insert and pop issued together");

endmodule

`default_nettype wire

FILE: hw/rtl/stq_ctrl.sv
// Controller state machine of the sorted timer expiry queue.
`default_nettype none

module stq_ctrl import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  stq_sts_t sts,
  output stq_cmd_t cmd,
  output logic     busy
);

  stq_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.req_tick) begin
          if (sts.tick_max) begin
            state_nxt = ST_REBASE;
          end else begin
            cmd.tick_inc = 1'b1;
            state_nxt    = ST_DRAIN;
          end
        end else if (sts.refused) begin
          cmd.out_refused = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.calc_exp = 1'b1;
          state_nxt    = sts.wrap ? ST_REBASE : ST_INSERT;
        end
      end
      ST_REBASE: begin
        cmd.rebase = 1'b1;
        state_nxt  = sts.req_tick ? ST_INCR : ST_INSERT;
      end
      ST_INCR: begin
        cmd.tick_inc = 1'b1;
        state_nxt    = ST_DRAIN;
      end
      ST_INSERT: begin
        cmd.insert  = 1'b1;
        cmd.out_arm = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_DRAIN: begin
        // only the first drain cycle can find the head not due
        if (sts.head_due) begin
          cmd.pop = 1'b1;
          if (!sts.next_due) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.out_none = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/stq_chain.sv
// Sorted cell chain holding queued expiries and timer ids.
`default_nettype none

module stq_chain import stq_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32,
  parameter int OCC_W      = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TICK_BITS-1:0] tick,
  input  logic [TICK_BITS-1:0] exp_new,
  input  logic [ID_W-1:0]      id_new,
  input  logic                 insert,
  input  logic                 rebase,
  input  logic                 pop,
  output logic [OCC_W-1:0]     occ,
  output logic [ID_W-1:0]      head_id,
  output logic                 head_due,
  output logic                 next_due
);

  logic [TICK_BITS-1:0] exp_q  [NUM_TIMERS];
  logic [ID_W-1:0]      id_q   [NUM_TIMERS];
  logic [TICK_BITS-1:0] up_exp [NUM_TIMERS];
  logic [ID_W-1:0]      up_id  [NUM_TIMERS];
  logic [TICK_BITS-1:0] dn_exp [NUM_TIMERS];
  logic [ID_W-1:0]      dn_id  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] live, le, ins_here;
  logic [OCC_W-1:0]     occ_r;

  // Per-cell compare against the new expiry and neighbor selection
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      live[i] = (int'(occ_r) > i);
      le[i]   = live[i] && (exp_q[i] <= exp_new);
    end
    ins_here[0] = 1'b1;
    up_exp[0]   = exp_new;
    up_id[0]    = id_new;
    for (int i = 1; i < NUM_TIMERS; i++) begin
      ins_here[i] = le[i-1];
      up_exp[i]   = exp_q[i-1];
      up_id[i]    = id_q[i-1];
    end
    for (int i = 0; i < NUM_TIMERS - 1; i++) begin
      dn_exp[i] = exp_q[i+1];
      dn_id[i]  = id_q[i+1];
    end
    dn_exp[NUM_TIMERS-1] = exp_q[NUM_TIMERS-1];
    dn_id[NUM_TIMERS-1]  = id_q[NUM_TIMERS-1];
  end

  // Cells: insert after all equal-or-earlier entries, rebase, or shift to head
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (insert) begin
        if (!le[i]) begin
          if (ins_here[i]) begin
            exp_q[i] <= exp_new;
            id_q[i]  <= id_new;
          end else begin
            exp_q[i] <= up_exp[i];
            id_q[i]  <= up_id[i];
          end
        end
      end else if (rebase) begin
        exp_q[i] <= exp_q[i] - tick;
      end else if (pop) begin
        exp_q[i] <= dn_exp[i];
        id_q[i]  <= dn_id[i];
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (insert) begin
      occ_r <= occ_r + OCC_W'(1);
    end else if (pop) begin
      occ_r <= occ_r - OCC_W'(1);
    end
  end

  assign occ      = occ_r;
  assign head_id  = id_q[0];
  assign head_due = live[0] && (exp_q[0] <= tick);
  assign next_due = live[1] && (exp_q[1] <= tick);

endmodule

`default_nettype wire

FILE: hw/rtl/stq_dp.sv
// Datapath: request capture, tick counter, armed flags, cell chain, result register.
`default_nettype none

module stq_dp import stq_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stq_in_t  in_req,
  input  stq_cmd_t cmd,
  output stq_sts_t sts,
  output logic     out_valid,
  output stq_out_t out_res
);

  localparam int OCC_W = $clog2(NUM_TIMERS + 1);

  stq_in_t              req_r;
  logic [TICK_BITS-1:0] tick_r;
  logic [TICK_BITS-1:0] exp_r;
  logic [TICK_BITS-1:0] dsat;
  logic [TICK_BITS:0]   sum;
  logic [NUM_IDS-1:0]   armed_r;
  logic [OCC_W-1:0]     occ;
  logic [ID_W-1:0]      head_id;
  logic                 head_due, next_due;
  logic                 out_valid_r;
  stq_out_t             out_r;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  // Delay saturated to the counter width
  generate
    if (TICK_BITS < DELAY_W) begin : g_sat
      assign dsat = (|req_r.defer_ticks[DELAY_W-1:TICK_BITS]) ? '1
                                                             : req_r.defer_ticks[TICK_BITS-1:0];
    end else begin : g_ext
      assign dsat = TICK_BITS'(req_r.defer_ticks);
    end
  endgenerate

  assign sum = {1'b0, tick_r} + {1'b0, dsat};

  // Tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (cmd.rebase) begin
      tick_r <= '0;
    end else if (cmd.tick_inc) begin
      tick_r <= tick_r + TICK_BITS'(1);
    end
  end

  // New expiry; on a wrap the rebased expiry is the delay itself
  always_ff @(posedge clk) begin
    if (cmd.calc_exp) begin
      exp_r <= sum[TICK_BITS] ? dsat : sum[TICK_BITS-1:0];
    end
  end

  // Armed flags per id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else if (cmd.insert) begin
      armed_r[req_r.timer_id] <= 1'b1;
    end else if (cmd.pop) begin
      armed_r[head_id] <= 1'b0;
    end
  end

  stq_chain #(
    .NUM_TIMERS (NUM_TIMERS),
    .TICK_BITS  (TICK_BITS),
    .OCC_W      (OCC_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick_r),
    .exp_new  (exp_r),
    .id_new   (req_r.timer_id),
    .insert   (cmd.insert),
    .rebase   (cmd.rebase),
    .pop      (cmd.pop),
    .occ      (occ),
    .head_id  (head_id),
    .head_due (head_due),
    .next_due (next_due)
  );

  // Status to the controller
  always_comb begin
    sts.req_tick = (req_r.req_type == REQ_TICK);
    sts.refused  = (int'(req_r.timer_id) >= NUM_TIMERS) || armed_r[req_r.timer_id] ||
                   (int'(occ) >= NUM_TIMERS);
    sts.wrap     = sum[TICK_BITS];
    sts.tick_max = &tick_r;
    sts.head_due = head_due;
    sts.next_due = next_due;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_arm | cmd.out_refused | cmd.out_none | cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_r <= '{add_status: 1'b0, expired_valid: 1'b1, expired_id: head_id,
                 last: !next_due};
    end else if (cmd.out_refused) begin
      out_r <= '{add_status: 1'b1, expired_valid: 1'b0, expired_id: '0, last: 1'b1};
    end else if (cmd.out_arm | cmd.out_none) begin
      out_r <= '{add_status: 1'b0, expired_valid: 1'b0, expired_id: '0, last: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire
